// ===== sv/csfd_pkg.sv =====
`timescale 1ns / 1ps

package csfd_pkg;

  // frame and word geometry
  localparam int unsigned FRAME_BYTES = 8;
  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned WORD_BYTES  = WORD_BITS / 8;

  // fixed point formats: scale fraction bits and output fraction bits
  localparam int unsigned SCALE_FRAC_BITS = 16;
  localparam int unsigned OUT_FRAC_BITS   = 16;
  localparam int unsigned FRAC_DOWN =
    (SCALE_FRAC_BITS > OUT_FRAC_BITS) ? (SCALE_FRAC_BITS - OUT_FRAC_BITS) : 0;
  localparam int unsigned FRAC_UP =
    (OUT_FRAC_BITS > SCALE_FRAC_BITS) ? (OUT_FRAC_BITS - SCALE_FRAC_BITS) : 0;

  // datapath widths: 65-bit signed numeric times 32-bit signed scale
  localparam int unsigned NUM_W   = 65;
  localparam int unsigned SCALE_W = 32;
  localparam int unsigned HALF_W  = 32;
  localparam int unsigned PART_W  = NUM_W;
  localparam int unsigned PROD_W  = NUM_W + SCALE_W;
  localparam int unsigned ALIGN_W = PROD_W + FRAC_UP;
  localparam int unsigned SUM_W   = ALIGN_W + 1;

  // queue between front and back
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // saturation limits
  localparam logic [63:0] PHYS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] PHYS_MIN = 64'h8000_0000_0000_0000;

  // one finished signal on its way to the scaling pipeline
  typedef struct packed {
    logic [63:0]              raw;
    logic signed [NUM_W-1:0]  num;
    logic signed [SCALE_W-1:0] scale;
    logic signed [63:0]       bias;
    logic                     err;
  } csfd_item_t;

  // queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } csfd_q_stat_t;

endpackage

// ===== sv/can_signal_field_decoder.sv =====
`timescale 1ns / 1ps

// CAN signal decoder. Each transaction on the input side is one signal part:
// a field is cut out of a little-endian 32-bit word of the frame and shifted
// into a 64-bit accumulator. A part with last_part set closes the signal and
// yields one result: the raw bits, the Q47.16 physical value (numeric times
// the Q16.16 scale plus the offset, saturated) and a flag for any part whose
// offset plus bit count passed 32. Parts are taken one per cycle while
// full is low; the accumulator is updated as each part is taken, so
// back-to-back parts of one signal need no gaps. A closed signal enters a
// four-entry queue and then a three-stage scaling pipeline (split multiply,
// recombine, offset add and saturate) whose output register drives the
// result ports. Full rises only while a result waits unpopped and the
// queue holds four closed signals, with up to two more held in the stalled
// pipeline.
module can_signal_field_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [63:0]        frame_data_i,
  input  logic [2:0]         byte_pos_i,
  input  logic [4:0]         bit_offset_i,
  input  logic [5:0]         bit_count_i,
  input  logic               last_part_i,
  input  logic               signed_mode_i,
  input  logic [6:0]         signal_width_i,
  input  logic signed [31:0] scale_i,
  input  logic signed [63:0] bias_i,
  output logic               empty,
  input  logic               pop,
  output logic [63:0]        raw_value_o,
  output logic signed [63:0] physical_value_o,
  output logic               part_error_o
);

  logic                   q_wr;
  logic                   q_rd;
  csfd_pkg::csfd_item_t   q_in;
  csfd_pkg::csfd_item_t   q_out;
  csfd_pkg::csfd_q_stat_t q_stat;

  assign full = q_stat.full;

  // part extraction and accumulation
  csfd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .stat_i         (q_stat),
    .frame_data_i   (frame_data_i),
    .byte_pos_i     (byte_pos_i),
    .bit_offset_i   (bit_offset_i),
    .bit_count_i    (bit_count_i),
    .last_part_i    (last_part_i),
    .signed_mode_i  (signed_mode_i),
    .signal_width_i (signal_width_i),
    .scale_i        (scale_i),
    .bias_i         (bias_i),
    .wr_o           (q_wr),
    .item_o         (q_in)
  );

  // queue of closed signals
  csfd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (q_wr),
    .item_i (q_in),
    .rd_i   (q_rd),
    .item_o (q_out),
    .stat_o (q_stat)
  );

  // scaling pipeline and result register
  csfd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_i           (q_out),
    .stat_i           (q_stat),
    .rd_o             (q_rd),
    .pop_i            (pop),
    .empty_o          (empty),
    .raw_value_o      (raw_value_o),
    .physical_value_o (physical_value_o),
    .part_error_o     (part_error_o)
  );

`ifndef SYNTHESIS
  // queue can never be full and empty at once
  a_q_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue full and empty together");

  // front never writes a full queue
  a_q_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_wr |-> !q_stat.full)
    else $error("write into full queue");

  // back never reads an empty queue
  a_q_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_rd |-> !q_stat.empty)
    else $error("read from empty queue");

  // a queue write with nothing read leaves the queue non-empty
  a_q_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_wr && !q_rd) |=> !q_stat.empty)
    else $error("queue lost a closed signal");
`endif

endmodule

// ===== sv/csfd_front.sv =====
`timescale 1ns / 1ps

module csfd_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  csfd_pkg::csfd_q_stat_t   stat_i,
  input  logic [63:0]              frame_data_i,
  input  logic [2:0]               byte_pos_i,
  input  logic [4:0]               bit_offset_i,
  input  logic [5:0]               bit_count_i,
  input  logic                     last_part_i,
  input  logic                     signed_mode_i,
  input  logic [6:0]               signal_width_i,
  input  logic signed [31:0]       scale_i,
  input  logic signed [63:0]       bias_i,
  output logic                     wr_o,
  output csfd_pkg::csfd_item_t     item_o
);

  logic [63:0] acc_q, acc_d;
  logic        err_q, err_d;
  logic        accept;

  logic [31:0] word;
  logic [3:0]  idx;
  logic [6:0]  span;
  logic        over;
  logic [5:0]  bits_c;
  logic [5:0]  shift;
  logic [31:0] mask;
  logic [31:0] field;
  logic [63:0] acc_new;

  logic [6:0]  width_c;
  logic [63:0] wmask;
  logic        sign_bit;
  logic [63:0] sval;
  logic signed [csfd_pkg::NUM_W-1:0] num;

  assign accept = push_i && !stat_i.full;

  // gather the little-endian word, bytes past the frame read as zero
  always_comb begin
    word = '0;
    idx  = '0;
    for (int b = 0; b < csfd_pkg::WORD_BYTES; b++) begin
      idx = {1'b0, byte_pos_i} + 4'(b);
      if (idx < 4'd8 && 32'(idx) < csfd_pkg::FRAME_BYTES) begin
        word[8*b +: 8] = frame_data_i[{idx[2:0], 3'b000} +: 8];
      end
    end
  end

  // field extraction and accumulator shift
  always_comb begin
    span    = {2'b00, bit_offset_i} + {1'b0, bit_count_i};
    over    = span > 7'd32;
    bits_c  = (bit_count_i > 6'd32) ? 6'd32 : bit_count_i;
    shift   = over ? 6'd0 : 6'(7'd32 - span);
    mask    = (bits_c >= 6'd32) ? '1 : ((32'd1 << bits_c) - 32'd1);
    field   = (word >> shift) & mask;
    acc_new = (bits_c == 6'd0) ? acc_q : ((acc_q << bits_c) | {32'b0, field});
  end

  // numeric value: sign-extend from the signal width in signed mode
  always_comb begin
    width_c  = (signal_width_i > 7'd64) ? 7'd64 : signal_width_i;
    wmask    = (width_c >= 7'd64) ? '1 : ((64'd1 << width_c[5:0]) - 64'd1);
    sign_bit = (width_c == 7'd0) ? 1'b0 : acc_new[width_c[5:0] - 6'd1];
    sval     = (acc_new & wmask) | (sign_bit ? ~wmask : 64'd0);
    if (signed_mode_i && width_c != 7'd0) begin
      num = {sval[63], sval};
    end else begin
      num = {1'b0, acc_new};
    end
  end

  // hand a finished signal to the queue
  always_comb begin
    wr_o         = accept && last_part_i;
    item_o.raw   = acc_new;
    item_o.num   = num;
    item_o.scale = scale_i;
    item_o.bias  = bias_i;
    item_o.err   = err_q | over;
  end

  // accumulator state, cleared after the last part
  always_comb begin
    acc_d = acc_q;
    err_d = err_q;
    if (accept) begin
      if (last_part_i) begin
        acc_d = '0;
        err_d = 1'b0;
      end else begin
        acc_d = acc_new;
        err_d = err_q | over;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      err_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      err_q <= err_d;
    end
  end

endmodule

// ===== sv/csfd_fifo.sv =====
`timescale 1ns / 1ps

module csfd_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   wr_i,
  input  csfd_pkg::csfd_item_t   item_i,
  input  logic                   rd_i,
  output csfd_pkg::csfd_item_t   item_o,
  output csfd_pkg::csfd_q_stat_t stat_o
);

  csfd_pkg::csfd_item_t mem_q [csfd_pkg::FIFO_DEPTH];

  logic [csfd_pkg::FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [csfd_pkg::FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [csfd_pkg::FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                            do_wr, do_rd;

  localparam logic [csfd_pkg::FIFO_PTR_W-1:0] PTR_LAST =
    csfd_pkg::FIFO_PTR_W'(csfd_pkg::FIFO_DEPTH - 1);
  localparam logic [csfd_pkg::FIFO_CNT_W-1:0] CNT_FULL =
    csfd_pkg::FIFO_CNT_W'(csfd_pkg::FIFO_DEPTH);

  assign stat_o.full  = (cnt_q == CNT_FULL);
  assign stat_o.empty = (cnt_q == '0);
  assign do_wr        = wr_i && !stat_o.full;
  assign do_rd        = rd_i && !stat_o.empty;
  assign item_o       = mem_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== sv/csfd_back.sv =====
`timescale 1ns / 1ps

module csfd_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  csfd_pkg::csfd_item_t          item_i,
  input  csfd_pkg::csfd_q_stat_t        stat_i,
  output logic                          rd_o,
  input  logic                          pop_i,
  output logic                          empty_o,
  output logic [63:0]                   raw_value_o,
  output logic signed [63:0]            physical_value_o,
  output logic                          part_error_o
);

  logic adv;

  // stage 1: partial products
  logic                                s1_v_q;
  logic [63:0]                         s1_raw_q;
  logic                                s1_err_q;
  logic signed [63:0]                  s1_bias_q;
  logic signed [csfd_pkg::PART_W-1:0]  s1_lo_q, s1_lo_d;
  logic signed [csfd_pkg::PART_W-1:0]  s1_hi_q, s1_hi_d;

  // stage 2: full product aligned to the output fraction
  logic                                s2_v_q;
  logic [63:0]                         s2_raw_q;
  logic                                s2_err_q;
  logic signed [63:0]                  s2_bias_q;
  logic signed [csfd_pkg::ALIGN_W-1:0] s2_al_q, s2_al_d;
  logic signed [csfd_pkg::PROD_W-1:0]  prod;
  logic signed [csfd_pkg::ALIGN_W-1:0] prod_ext;

  // output register
  logic                                out_v_q;
  logic signed [csfd_pkg::SUM_W-1:0]   sum;
  logic [csfd_pkg::SUM_W-64:0]         upper;
  logic                                fits;
  logic [63:0]                         phys_d;

  // the whole pipeline moves when the output slot is free or being taken
  assign adv     = !out_v_q || pop_i;
  assign rd_o    = adv && !stat_i.empty;
  assign empty_o = !out_v_q;

  // split multiply: low unsigned half and high signed half of the numeric
  always_comb begin
    s1_lo_d = csfd_pkg::PART_W'($signed({1'b0, item_i.num[csfd_pkg::HALF_W-1:0]}))
            * csfd_pkg::PART_W'(item_i.scale);
    s1_hi_d = csfd_pkg::PART_W'($signed(item_i.num[csfd_pkg::NUM_W-1:csfd_pkg::HALF_W]))
            * csfd_pkg::PART_W'(item_i.scale);
  end

  // recombine the halves and align the fraction
  always_comb begin
    prod = $signed({s1_hi_q, {csfd_pkg::HALF_W{1'b0}}})
         + $signed({{csfd_pkg::HALF_W{s1_lo_q[csfd_pkg::PART_W-1]}}, s1_lo_q});
    prod_ext = $signed({{csfd_pkg::FRAC_UP{prod[csfd_pkg::PROD_W-1]}}, prod});
    s2_al_d  = (prod_ext <<< csfd_pkg::FRAC_UP) >>> csfd_pkg::FRAC_DOWN;
  end

  // add the offset and saturate to 64 bits
  always_comb begin
    sum = $signed({s2_al_q[csfd_pkg::ALIGN_W-1], s2_al_q})
        + $signed({{(csfd_pkg::SUM_W-64){s2_bias_q[63]}}, s2_bias_q});
    upper  = sum[csfd_pkg::SUM_W-1:63];
    fits   = (&upper) || !(|upper);
    phys_d = fits ? sum[63:0]
                  : (sum[csfd_pkg::SUM_W-1] ? csfd_pkg::PHYS_MIN : csfd_pkg::PHYS_MAX);
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q  <= !stat_i.empty;
      s2_v_q  <= s1_v_q;
      out_v_q <= s2_v_q;
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_raw_q         <= item_i.raw;
      s1_err_q         <= item_i.err;
      s1_bias_q        <= item_i.bias;
      s1_lo_q          <= s1_lo_d;
      s1_hi_q          <= s1_hi_d;
      s2_raw_q         <= s1_raw_q;
      s2_err_q         <= s1_err_q;
      s2_bias_q        <= s1_bias_q;
      s2_al_q          <= s2_al_d;
      raw_value_o      <= s2_raw_q;
      part_error_o     <= s2_err_q;
      physical_value_o <= phys_d;
    end
  end

endmodule
